// ----- sv/fccm_pkg.sv -----
`default_nettype none
package fccm_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned FORMAT_MAX  = 4096;
  localparam int unsigned CL_W        = 12;
  localparam int unsigned LEN_W       = 13;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_LINK = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_NEW    = 3'd0,
    OP_EXTEND = 3'd1,
    OP_FREE   = 3'd2,
    OP_TRUNC  = 3'd3,
    OP_LOOKUP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADARG  = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ----- sv/fccm_ram.sv -----
`default_nettype none
module fccm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/fat_cluster_chain_manager_top.sv -----
// A bad op or an out-of-range start cluster is answered straight from idle, and a free start
// cluster once its table entry is read; other ops walk the chain link by link, scan the
// table entry by entry for a free cluster and free the chain cluster by cluster.
// One command at a time; busy is high until the result strobe cycle.
// Reset and every cluster_count write run a format pass over all TableDepth table entries.
// The receiver cannot stall: each result is shown for one cycle on done_o.
`default_nettype none
module fat_cluster_chain_manager_top
  import fccm_pkg::*;
#(
  parameter int unsigned TableDepth = TABLE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        op_i,
  input  wire logic [CL_W-1:0]   start_cluster_i,
  input  wire logic [LEN_W-1:0]  amount_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [CL_W-1:0]        cluster_o,
  output logic [LEN_W-1:0]       chain_length_o,
  output logic [LEN_W-1:0]       free_count_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned AW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = (AW + 1 > 14) ? AW + 1 : 14;
  localparam int unsigned DW   = AW + 2;
  localparam int unsigned ResetCnt = (TableDepth < FORMAT_MAX) ? TableDepth : FORMAT_MAX;

  typedef enum logic [12:0] {
    S_FMT    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_WSTART = 13'b0000000000100,
    S_CHK    = 13'b0000000001000,
    S_WSTEP  = 13'b0000000010000,
    S_WNEXT  = 13'b0000000100000,
    S_SCAN   = 13'b0000001000000,
    S_EXTLNK = 13'b0000010000000,
    S_RSTEP  = 13'b0000100000000,
    S_RNEXT  = 13'b0001000000000,
    S_TFOL   = 13'b0010000000000,
    S_TEND   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_e;

  typedef enum logic [2:0] {
    PH_NEW, PH_EXT1, PH_EXT2, PH_FREE, PH_TRN, PH_LK1, PH_LK2
  } phase_e;

  state_e          state_q, state_d;
  phase_e          ph_q, ph_d;
  logic [CntW-1:0] cc_q, cc_d, ft_q, ft_d;
  logic [AW-1:0]   fmt_q, fmt_d;
  logic [CntW-1:0] start_q, start_d;
  logic [LEN_W-1:0] amt_q, amt_d;
  logic [AW-1:0]   c_q, c_d, tl_q, tl_d;
  kind_e           ek_q, ek_d;
  logic [AW-1:0]   el_q, el_d;
  logic [CntW-1:0] len_q, len_d, lim_q, lim_d, keep_q, keep_d;
  logic [CntW-1:0] rem_q, rem_d, pend_q, pend_d, steps_q, steps_d;
  logic            done_q, done_d;
  logic [1:0]      st_q, st_d;
  logic [CL_W-1:0] cl_q, cl_d;
  logic [LEN_W-1:0] lo_q, lo_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  kind_e         rk;
  logic [AW-1:0] rl;

  logic            cfg_wr;
  logic [LEN_W-1:0] cfg_v;
  logic [CntW-1:0] cfg_sat;
  logic            walk_done, rel_done;
  logic [CntW-1:0] keep_amt;

  fccm_ram #(.Width(DW), .Depth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rk = kind_e'(mem_rdata[DW-1:AW]);
  assign rl = mem_rdata[AW-1:0];

  assign cfg_wr  = psel && penable && pwrite && !paddr[2];
  assign cfg_v   = pwdata[LEN_W-1:0];
  assign pready  = 1'b1;
  assign prdata  = paddr[2] ? 32'd0 : 32'(cc_q);
  assign keep_amt = (amt_q == '0) ? CntW'(1) : CntW'(amt_q);

  always_comb begin
    if (cfg_v == '0) begin
      cfg_sat = CntW'(1);
    end else if (CntW'(cfg_v) > CntW'(TableDepth)) begin
      cfg_sat = CntW'(TableDepth);
    end else begin
      cfg_sat = CntW'(cfg_v);
    end
  end

  always_comb begin
    state_d = state_q;  ph_d = ph_q;    cc_d = cc_q;     ft_d = ft_q;
    fmt_d = fmt_q;      start_d = start_q; amt_d = amt_q;
    c_d = c_q;          tl_d = tl_q;    ek_d = ek_q;     el_d = el_q;
    len_d = len_q;      lim_d = lim_q;  keep_d = keep_q; rem_d = rem_q;
    pend_d = pend_q;    steps_d = steps_q;
    done_d = 1'b0;      st_d = st_q;    cl_d = cl_q;     lo_d = lo_q;
    mem_we = 1'b0;      mem_waddr = c_q; mem_wdata = {KIND_FREE, {AW{1'b0}}};
    mem_raddr = '0;
    walk_done = 1'b0;   rel_done = 1'b0;

    case (state_q)
      S_FMT: begin
        mem_we    = 1'b1;
        mem_waddr = fmt_q;
        mem_wdata = (fmt_q == '0) ? {KIND_END, {AW{1'b0}}} : {KIND_FREE, {AW{1'b0}}};
        fmt_d     = fmt_q + 1'b1;
        if (CntW'(fmt_q) == CntW'(TableDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          start_d = CntW'(start_cluster_i);
          amt_d   = amount_i;
          lim_d   = cc_q;
          if (op_i == OP_NEW) begin
            ph_d = PH_NEW;  pend_d = '0;  mem_raddr = '0;  state_d = S_SCAN;
          end else if (op_i > OP_LOOKUP || CntW'(start_cluster_i) >= cc_q) begin
            done_d = 1'b1;  st_d = ST_BADARG;  cl_d = '0;  lo_d = '0;
          end else begin
            mem_raddr = AW'(CntW'(start_cluster_i));
            state_d   = S_CHK;
            case (op_i)
              OP_EXTEND: ph_d = PH_EXT1;
              OP_FREE:   ph_d = PH_FREE;
              OP_TRUNC:  ph_d = PH_TRN;
              default:   ph_d = PH_LK1;
            endcase
          end
        end
      end
      S_WSTART: begin
        mem_raddr = AW'(start_q);
        state_d   = S_CHK;
      end
      S_CHK: begin
        c_d = AW'(start_q);  ek_d = rk;  el_d = rl;  len_d = CntW'(1);  steps_d = '0;
        if (ph_q == PH_EXT2 || ph_q == PH_LK2) begin
          state_d = S_WSTEP;
        end else if (rk == KIND_FREE) begin
          done_d = 1'b1;  st_d = ST_BADARG;  cl_d = '0;  lo_d = '0;  state_d = S_IDLE;
        end else if (ph_q == PH_FREE) begin
          state_d = S_RSTEP;
        end else begin
          if (ph_q == PH_TRN) begin
            lim_d = keep_amt;
          end
          state_d = S_WSTEP;
        end
      end
      S_WSTEP: begin
        if (len_q < lim_q && len_q < cc_q && ek_q == KIND_LINK && CntW'(el_q) < cc_q) begin
          mem_raddr = el_q;
          state_d   = S_WNEXT;
        end else begin
          walk_done = 1'b1;
        end
      end
      S_WNEXT: begin
        if (rk == KIND_FREE) begin
          walk_done = 1'b1;
        end else begin
          c_d = el_q;  ek_d = rk;  el_d = rl;  len_d = len_q + 1'b1;
          state_d = S_WSTEP;
        end
      end
      S_SCAN: begin
        if (pend_q >= cc_q) begin
          if (ph_q == PH_NEW) begin
            done_d = 1'b1;  st_d = ST_NOSPACE;  cl_d = '0;  lo_d = '0;  state_d = S_IDLE;
          end else begin
            ph_d = PH_EXT2;  state_d = S_WSTART;
          end
        end else if (rk == KIND_FREE) begin
          mem_we = 1'b1;
          if (ph_q == PH_NEW) begin
            mem_waddr = AW'(pend_q);
            mem_wdata = {KIND_END, {AW{1'b0}}};
            ft_d   = ft_q - 1'b1;
            done_d = 1'b1;  st_d = ST_OK;  cl_d = CL_W'(pend_q);  lo_d = LEN_W'(1);
            state_d = S_IDLE;
          end else begin
            mem_waddr = c_q;
            mem_wdata = {KIND_LINK, AW'(pend_q)};
            state_d   = S_EXTLNK;
          end
        end else begin
          pend_d    = pend_q + 1'b1;
          mem_raddr = AW'(pend_q + 1'b1);
        end
      end
      S_EXTLNK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pend_q);
        mem_wdata = {KIND_END, {AW{1'b0}}};
        ft_d  = ft_q - 1'b1;
        c_d   = AW'(pend_q);
        rem_d = rem_q - 1'b1;
        if (rem_q == CntW'(1)) begin
          ph_d = PH_EXT2;  state_d = S_WSTART;
        end else begin
          pend_d    = pend_q + 1'b1;
          mem_raddr = AW'(pend_q + 1'b1);
          state_d   = S_SCAN;
        end
      end
      S_RSTEP: begin
        if (ek_q == KIND_LINK && CntW'(el_q) < cc_q) begin
          mem_raddr = el_q;
          state_d   = S_RNEXT;
        end else begin
          if (ek_q != KIND_FREE) begin
            mem_we = 1'b1;  mem_waddr = c_q;  ft_d = ft_q + 1'b1;
          end
          rel_done = 1'b1;
        end
      end
      S_RNEXT: begin
        if (ek_q != KIND_FREE) begin
          mem_we = 1'b1;  mem_waddr = c_q;  ft_d = ft_q + 1'b1;
        end
        if (rk != KIND_FREE && steps_q + 1'b1 < cc_q) begin
          steps_d = steps_q + 1'b1;
          c_d     = el_q;
          if (el_q == c_q) begin
            ek_d = KIND_FREE;  el_d = '0;
          end else begin
            ek_d = rk;  el_d = rl;
          end
          state_d = S_RSTEP;
        end else begin
          rel_done = 1'b1;
        end
      end
      S_TFOL: begin
        if (rk == KIND_FREE) begin
          state_d = S_TEND;
        end else begin
          c_d = el_q;  ek_d = rk;  el_d = rl;  steps_d = '0;
          state_d = S_RSTEP;
        end
      end
      S_TEND: begin
        mem_we    = 1'b1;
        mem_waddr = tl_q;
        mem_wdata = {KIND_END, {AW{1'b0}}};
        done_d = 1'b1;  st_d = ST_OK;  cl_d = CL_W'(tl_q);  lo_d = LEN_W'(len_q);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (walk_done) begin
      case (ph_q)
        PH_EXT1: begin
          if (ft_q < CntW'(amt_q)) begin
            done_d = 1'b1;  st_d = ST_NOSPACE;  cl_d = CL_W'(c_q);  lo_d = LEN_W'(len_q);
            state_d = S_IDLE;
          end else if (amt_q == '0) begin
            done_d = 1'b1;  st_d = ST_OK;  cl_d = CL_W'(c_q);  lo_d = LEN_W'(len_q);
            state_d = S_IDLE;
          end else begin
            rem_d = CntW'(amt_q);  pend_d = '0;  mem_raddr = '0;  state_d = S_SCAN;
          end
        end
        PH_TRN: begin
          tl_d = c_q;
          if (ek_q == KIND_LINK && CntW'(el_q) < cc_q) begin
            mem_raddr = el_q;  state_d = S_TFOL;
          end else begin
            state_d = S_TEND;
          end
        end
        PH_LK1: begin
          keep_d  = len_q;
          lim_d   = CntW'(amt_q) + 1'b1;
          ph_d    = PH_LK2;
          state_d = S_WSTART;
        end
        PH_LK2: begin
          done_d = 1'b1;  st_d = ST_OK;  cl_d = CL_W'(c_q);  lo_d = LEN_W'(keep_q);
          state_d = S_IDLE;
        end
        default: begin
          done_d = 1'b1;  st_d = ST_OK;  cl_d = CL_W'(c_q);  lo_d = LEN_W'(len_q);
          state_d = S_IDLE;
        end
      endcase
    end

    if (rel_done) begin
      if (ph_q == PH_TRN) begin
        state_d = S_TEND;
      end else begin
        done_d = 1'b1;  st_d = ST_OK;  cl_d = '0;  lo_d = '0;  state_d = S_IDLE;
      end
    end

    if (cfg_wr) begin
      cc_d    = cfg_sat;
      ft_d    = cfg_sat - 1'b1;
      fmt_d   = '0;
      state_d = S_FMT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FMT;
      ph_q    <= PH_NEW;
      cc_q    <= CntW'(ResetCnt);
      ft_q    <= CntW'(ResetCnt - 1);
      fmt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      cc_q    <= cc_d;
      ft_q    <= ft_d;
      fmt_q   <= fmt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;  amt_q <= amt_d;   c_q <= c_d;       tl_q <= tl_d;
    ek_q    <= ek_d;     el_q <= el_d;     len_q <= len_d;   lim_q <= lim_d;
    keep_q  <= keep_d;   rem_q <= rem_d;   pend_q <= pend_d; steps_q <= steps_d;
    st_q    <= st_d;     cl_q <= cl_d;     lo_q <= lo_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = st_q;
  assign cluster_o      = cl_q;
  assign chain_length_o = lo_q;
  assign free_count_o   = LEN_W'(ft_q);

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result strobe without a command in flight");

  a_free_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ft_q <= cc_q)
    else $error("free count exceeds cluster count");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither running nor answered");

endmodule
`default_nettype wire
